// ===== sv/fmma_pkg.sv =====
// ----------------------------------------------------------------------------
// fmma_pkg
// Types and constants shared by the four-motor moving-average PWM block.
// ----------------------------------------------------------------------------
package fmma_pkg;

  localparam int NUM_MOTORS  = 4;
  localparam int MOTOR_IDX_W = 2;
  localparam int CMD_W       = 8;
  localparam int DUTY_W      = 8;

  // configuration port
  localparam int CFG_INDEX_W = 4;

  // clamp limit of the averaged drive, percent
  localparam logic signed [CMD_W-1:0] DRIVE_MAX = 8'sd100;
  localparam logic signed [CMD_W-1:0] DRIVE_MIN = -8'sd100;

  // duty = floor(255 * x / 200) for x = 100 + t in 0..200,
  // done as floor(x * ceil(2^20 * 51 / 40) / 2^20), exact over that range
  localparam int DUTY_OFFSET_W = 9;
  localparam logic signed [DUTY_OFFSET_W-1:0] DUTY_OFFSET = 9'sd100;
  localparam int DUTY_SHIFT  = 20;
  localparam int DUTY_MUL_W  = 21;
  localparam logic [DUTY_MUL_W-1:0] DUTY_MUL = 21'd1336935;
  localparam int DUTY_PROD_W = DUTY_MUL_W + DUTY_W;

  typedef struct packed {
    logic signed [CMD_W-1:0] cmd_motor0;
    logic signed [CMD_W-1:0] cmd_motor1;
    logic signed [CMD_W-1:0] cmd_motor2;
    logic signed [CMD_W-1:0] cmd_motor3;
  } in_t;

  typedef struct packed {
    logic signed [CMD_W-1:0] drive_motor0;
    logic signed [CMD_W-1:0] drive_motor1;
    logic signed [CMD_W-1:0] drive_motor2;
    logic signed [CMD_W-1:0] drive_motor3;
    logic [DUTY_W-1:0]       duty_motor0;
    logic [DUTY_W-1:0]       duty_motor1;
    logic [DUTY_W-1:0]       duty_motor2;
    logic [DUTY_W-1:0]       duty_motor3;
  } out_t;

endpackage

// ===== sv/fmma_window.sv =====
// ----------------------------------------------------------------------------
// fmma_window
// Command ring and running sums of the four lanes; one slot per transfer.
// ----------------------------------------------------------------------------
module fmma_window #(
  parameter int WINDOW_DEPTH = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 load,
  input  fmma_pkg::in_t        cmd,
  output logic [fmma_pkg::NUM_MOTORS-1:0][fmma_pkg::CMD_W+$clog2(WINDOW_DEPTH)-1:0] sums
);
  import fmma_pkg::*;

  localparam int SUM_W  = CMD_W + $clog2(WINDOW_DEPTH);
  localparam int SLOT_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;

  in_t                     ring [WINDOW_DEPTH];
  logic [WINDOW_DEPTH-1:0] entry_valid;
  logic [SLOT_W-1:0]       slot;
  logic [SLOT_W-1:0]       slot_next;
  logic [SLOT_W-1:0]       rd_addr;
  in_t                     rd_data;
  logic                    rd_valid;
  logic                    bypass;
  in_t                     last_cmd;
  in_t                     old;

  logic signed [CMD_W-1:0] cmd_l [NUM_MOTORS];
  logic signed [CMD_W-1:0] old_l [NUM_MOTORS];

  assign slot_next = (slot == SLOT_W'(WINDOW_DEPTH - 1)) ? '0 : slot + 1'b1;
  // prefetch the slot that the next transfer overwrites
  assign rd_addr   = load ? slot_next : slot;

  always_ff @(posedge clk) begin
    if (load) begin
      ring[slot] <= cmd;
      last_cmd   <= cmd;
    end
    rd_data <= ring[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot        <= '0;
      entry_valid <= '0;
      rd_valid    <= 1'b0;
      bypass      <= 1'b0;
    end else begin
      if (load) begin
        slot              <= slot_next;
        entry_valid[slot] <= 1'b1;
      end
      // a one-deep ring reads back the slot being written
      bypass   <= load && (rd_addr == slot);
      rd_valid <= entry_valid[rd_addr] || (load && (rd_addr == slot));
    end
  end

  always_comb begin
    if (!rd_valid) begin
      old = '0;
    end else if (bypass) begin
      old = last_cmd;
    end else begin
      old = rd_data;
    end
  end

  assign cmd_l[0] = cmd.cmd_motor0;
  assign cmd_l[1] = cmd.cmd_motor1;
  assign cmd_l[2] = cmd.cmd_motor2;
  assign cmd_l[3] = cmd.cmd_motor3;
  assign old_l[0] = old.cmd_motor0;
  assign old_l[1] = old.cmd_motor1;
  assign old_l[2] = old.cmd_motor2;
  assign old_l[3] = old.cmd_motor3;

  always_ff @(posedge clk) begin
    if (rst) begin
      sums <= '0;
    end else if (load) begin
      for (int m = 0; m < NUM_MOTORS; m++) begin
        sums[m] <= sums[m] + SUM_W'($signed(cmd_l[m])) - SUM_W'($signed(old_l[m]));
      end
    end
  end

endmodule

// ===== sv/fmma_avg.sv =====
// ----------------------------------------------------------------------------
// fmma_avg
// Window sum divided by the depth, truncated toward zero.
// ----------------------------------------------------------------------------
module fmma_avg #(
  parameter int WINDOW_DEPTH = 8
) (
  input  logic [fmma_pkg::CMD_W+$clog2(WINDOW_DEPTH)-1:0] sum,
  output logic signed [fmma_pkg::CMD_W-1:0]               avg
);
  import fmma_pkg::*;

  localparam int L       = $clog2(WINDOW_DEPTH);
  localparam int SUM_W   = CMD_W + L;
  localparam int SHIFT   = SUM_W + L;
  localparam int RECIP_W = SUM_W + 1;
  localparam int PROD_W  = SUM_W + RECIP_W;
  // ceil(2^SHIFT / depth) gives an exact floor for every magnitude below 2^SUM_W
  localparam longint unsigned RECIP_FULL =
    ((64'd1 << SHIFT) + 64'(WINDOW_DEPTH) - 64'd1) / 64'(WINDOW_DEPTH);
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_FULL);

  logic              neg;
  logic [SUM_W-1:0]  mag;
  logic [PROD_W-1:0] prod;
  logic [CMD_W-1:0]  quot;
  logic [CMD_W:0]    signed_quot;

  assign neg  = sum[SUM_W-1];
  assign mag  = neg ? SUM_W'(-sum) : sum;
  assign prod = PROD_W'(mag) * PROD_W'(RECIP);
  // quotient magnitude never exceeds 128
  assign quot = prod[SHIFT +: CMD_W];
  assign signed_quot = neg ? -{1'b0, quot} : {1'b0, quot};
  assign avg  = signed_quot[CMD_W-1:0];

endmodule

// ===== sv/fmma_drive.sv =====
// ----------------------------------------------------------------------------
// fmma_drive
// Clamp of the average, direction invert and PWM duty scaling of one lane.
// ----------------------------------------------------------------------------
module fmma_drive (
  input  logic signed [fmma_pkg::CMD_W-1:0] avg,
  input  logic                              invert,
  output logic signed [fmma_pkg::CMD_W-1:0] drive,
  output logic [fmma_pkg::DUTY_W-1:0]       duty
);
  import fmma_pkg::*;

  logic signed [CMD_W-1:0]         t;
  logic signed [DUTY_OFFSET_W-1:0] level;
  logic [DUTY_PROD_W-1:0]          prod;

  always_comb begin
    if (avg > DRIVE_MAX) begin
      drive = DRIVE_MAX;
    end else if (avg < DRIVE_MIN) begin
      drive = DRIVE_MIN;
    end else begin
      drive = avg;
    end
  end

  assign t     = invert ? -drive : drive;
  // level runs 0..200
  assign level = DUTY_OFFSET + DUTY_OFFSET_W'(t);
  assign prod  = DUTY_PROD_W'(level[DUTY_W-1:0]) * DUTY_PROD_W'(DUTY_MUL);
  assign duty  = prod[DUTY_SHIFT +: DUTY_W];

endmodule

// ===== sv/four_motor_moving_average_pwm_top.sv =====
// ----------------------------------------------------------------------------
// four_motor_moving_average_pwm_top
// Moving average over a ring of motor commands, clamp and PWM duty per motor.
// ----------------------------------------------------------------------------
//   channel | signals                              | direction
//   in      | in_valid, in_ready, in_data          | commands in
//   out     | out_valid, out_ready, out_data       | drive and duty out
//   cfg     | cfg_valid, cfg_ready, cfg_index/data | invert bits in, always ready
//
// one transfer per cycle unless the output stalls; out_valid follows the input
// transfer through the window update, divide and clamp/duty scaling registers
// the ring slot read is prefetched ahead of its use, beside the slot write
// reset clears the sums, the slot pointer and the per-slot valid bits at once
// a stalled output holds the pipe; input stays ready while any stage can move
// ----------------------------------------------------------------------------
module four_motor_moving_average_pwm_top #(
  parameter int WINDOW_DEPTH = 8
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  fmma_pkg::in_t                    in_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output fmma_pkg::out_t                   out_data,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [fmma_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic                             cfg_data
);
  import fmma_pkg::*;

  localparam int SUM_W = CMD_W + $clog2(WINDOW_DEPTH);

  logic                                  in_xfer;
  logic                                  sum_valid;
  logic                                  avg_valid;
  logic                                  avg_load;
  logic                                  out_load;
  logic [NUM_MOTORS-1:0]                 invert;
  logic [NUM_MOTORS-1:0][SUM_W-1:0]      sums;
  logic signed [CMD_W-1:0]               avg_next [NUM_MOTORS];
  logic signed [CMD_W-1:0]               avg_q    [NUM_MOTORS];
  logic signed [CMD_W-1:0]               drive    [NUM_MOTORS];
  logic [DUTY_W-1:0]                     duty     [NUM_MOTORS];

  assign out_load = avg_valid && (!out_valid || out_ready);
  assign avg_load = sum_valid && (!avg_valid || out_load);
  assign in_ready = !sum_valid || avg_load;
  assign in_xfer  = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  fmma_window #(
    .WINDOW_DEPTH(WINDOW_DEPTH)
  ) u_window (
    .clk  (clk),
    .rst  (rst),
    .load (in_xfer),
    .cmd  (in_data),
    .sums (sums)
  );

  for (genvar m = 0; m < NUM_MOTORS; m++) begin : g_lane
    fmma_avg #(
      .WINDOW_DEPTH(WINDOW_DEPTH)
    ) u_avg (
      .sum (sums[m]),
      .avg (avg_next[m])
    );

    fmma_drive u_drive (
      .avg    (avg_q[m]),
      .invert (invert[m]),
      .drive  (drive[m]),
      .duty   (duty[m])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      invert    <= '0;
      sum_valid <= 1'b0;
      avg_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_valid && (cfg_index < CFG_INDEX_W'(NUM_MOTORS))) begin
        invert[cfg_index[MOTOR_IDX_W-1:0]] <= cfg_data;
      end
      if (in_xfer) begin
        sum_valid <= 1'b1;
      end else if (avg_load) begin
        sum_valid <= 1'b0;
      end
      if (avg_load) begin
        avg_valid <= 1'b1;
      end else if (out_load) begin
        avg_valid <= 1'b0;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (avg_load) begin
      for (int m = 0; m < NUM_MOTORS; m++) begin
        avg_q[m] <= avg_next[m];
      end
    end
    if (out_load) begin
      out_data.drive_motor0 <= drive[0];
      out_data.drive_motor1 <= drive[1];
      out_data.drive_motor2 <= drive[2];
      out_data.drive_motor3 <= drive[3];
      out_data.duty_motor0  <= duty[0];
      out_data.duty_motor1  <= duty[1];
      out_data.duty_motor2  <= duty[2];
      out_data.duty_motor3  <= duty[3];
    end
  end

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Checks the four-motor moving-average PWM block. A local predictor tracks
// the command ring, the running sums and the invert bits and works out the
// drive and duty of every motor for each accepted command set. Stimulus is a
// short directed run over ring fill, clamp limits and out-of-range commands,
// then random runs under several invert settings, with bursty input and a
// stalling output side.
// ----------------------------------------------------------------------------
module testbench;
  import fmma_pkg::*;

  localparam int RING_DEPTH    = 8;
  localparam int IDLE_LIMIT    = 1000;
  localparam int SETTLE_CYCLES = 8;
  localparam int ITEMS_PER_SET = 66;
  localparam int REPORT_MAX    = 40;
  localparam int NUM_FIELDS    = 2 * NUM_MOTORS;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  in_t                    in_data = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  out_t                   out_data;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic                   cfg_data = 1'b0;

  // predictor state
  int                   ring_cmds [RING_DEPTH][NUM_MOTORS];
  int                   ring_sums [NUM_MOTORS];
  int                   ring_slot = 0;
  logic [NUM_MOTORS-1:0] invert_mask = '0;

  in_t  cmd_backlog[$];
  out_t pending_results[$];
  int   errors = 0;
  int   burst_left = 0;
  int   gap_left = 0;
  int   stall_mode = 0;
  int   stall_left = 0;
  int   idle_cycles = 0;

  string field_name [NUM_FIELDS] = '{"drive_motor0", "drive_motor1", "drive_motor2",
    "drive_motor3", "duty_motor0", "duty_motor1", "duty_motor2", "duty_motor3"};

  four_motor_moving_average_pwm_top #(.WINDOW_DEPTH(RING_DEPTH)) uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // one command set enters the ring; returns drive and duty of all motors
  function automatic out_t predict_motor_outputs(in_t cmds);
    logic signed [CMD_W-1:0] lane [NUM_MOTORS];
    logic [CMD_W-1:0]        drive [NUM_MOTORS];
    logic [DUTY_W-1:0]       duty [NUM_MOTORS];
    int                      avg;
    int                      t;
    lane[0] = cmds.cmd_motor0;
    lane[1] = cmds.cmd_motor1;
    lane[2] = cmds.cmd_motor2;
    lane[3] = cmds.cmd_motor3;
    for (int m = 0; m < NUM_MOTORS; m++) begin
      ring_sums[m] -= ring_cmds[ring_slot][m];
      ring_cmds[ring_slot][m] = int'(lane[m]);
      ring_sums[m] += int'(lane[m]);
      avg = ring_sums[m] / RING_DEPTH;
      if (avg > 100) avg = 100;
      if (avg < -100) avg = -100;
      t = invert_mask[m] ? -avg : avg;
      drive[m] = avg[CMD_W-1:0];
      duty[m] = DUTY_W'((255 * (100 + t)) / 200);
    end
    ring_slot = (ring_slot + 1) % RING_DEPTH;
    return '{drive[0], drive[1], drive[2], drive[3], duty[0], duty[1], duty[2], duty[3]};
  endfunction

  function automatic logic [CMD_W-1:0] pick_cmd(int mode);
    logic [CMD_W-1:0] v;
    case (mode)
      0: v = CMD_W'($urandom_range(0, 255));
      1: v = CMD_W'(int'($urandom_range(0, 200)) - 100);
      2: begin
        case ($urandom_range(0, 9))
          0: v = -8'sd128;
          1: v = -8'sd127;
          2: v = -8'sd101;
          3: v = -8'sd100;
          4: v = -8'sd99;
          5: v = 8'sd99;
          6: v = 8'sd100;
          7: v = 8'sd101;
          8: v = 8'sd126;
          default: v = 8'sd127;
        endcase
      end
      default: v = CMD_W'(int'($urandom_range(0, 10)) - 5);
    endcase
    return v;
  endfunction

  function automatic in_t make_cmds(int mode);
    return '{pick_cmd(mode), pick_cmd(mode), pick_cmd(mode), pick_cmd(mode)};
  endfunction

  task automatic write_invert(input logic [CFG_INDEX_W-1:0] idx, input logic val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    forever begin
      @(posedge clk);
      if (cfg_ready) break;
    end
    if (idx < NUM_MOTORS) invert_mask[idx] = val;
    cfg_valid <= 1'b0;
  endtask

  // pause the caller until every queued set has been sent and checked
  // sampled mid-cycle so the sender and monitor updates have settled
  task automatic drain_all;
    do @(negedge clk);
    while (cmd_backlog.size() != 0 || in_valid || pending_results.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // sender: bursts of random length with random gaps
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (cmd_backlog.size() != 0) begin
        in_data  <= cmd_backlog.pop_front();
        in_valid <= 1'b1;
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 24);
          gap_left = ($urandom_range(0, 1) == 0) ? 0 :
                     ($urandom_range(0, 3) == 0) ? $urandom_range(4, 15) : $urandom_range(1, 3);
        end else begin
          burst_left--;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver: stall pattern changes mode whenever its random run counter expires
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(16, 80);
    end else begin
      stall_left--;
    end
    case (stall_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= 1'($urandom_range(0, 1));
      2: out_ready <= ($urandom_range(0, 3) == 0);
      default: out_ready <= stall_left[2];
    endcase
  end

  // input transfers feed the predictor, output transfers are checked
  always @(posedge clk) begin
    logic [8*NUM_FIELDS-1:0] want;
    logic [8*NUM_FIELDS-1:0] got;
    if (!rst) begin
      if (in_valid && in_ready) pending_results.push_back(predict_motor_outputs(in_data));
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          errors++;
          if (errors <= REPORT_MAX)
            $display("%0t: unexpected result, expected none, actual %h", $time, out_data);
        end else begin
          want = pending_results.pop_front();
          got  = out_data;
          for (int f = 0; f < NUM_FIELDS; f++) begin
            if (got[8*(NUM_FIELDS-f)-1 -: 8] !== want[8*(NUM_FIELDS-f)-1 -: 8]) begin
              errors++;
              if (errors <= REPORT_MAX)
                $display("%0t: %s mismatch, expected %0d actual %0d", $time, field_name[f],
                         want[8*(NUM_FIELDS-f)-1 -: 8], got[8*(NUM_FIELDS-f)-1 -: 8]);
            end
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
      $display("RESULT: ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    logic [NUM_MOTORS-1:0] mask;
    int                    count;
    int                    mode;
    int                    run_len;
    in_t                   held;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // ring fill from cleared slots, both clamp limits, out-of-range commands
    repeat (8) cmd_backlog.push_back('{8'sd127, -8'sd128, 8'sd100, -8'sd100});
    repeat (8) cmd_backlog.push_back('{-8'sd128, 8'sd127, -8'sd101, 8'sd101});
    cmd_backlog.push_back('{8'sd0, 8'sd0, 8'sd0, 8'sd0});
    cmd_backlog.push_back('{8'sd1, -8'sd1, 8'sd7, -8'sd7});
    cmd_backlog.push_back('{-8'sd8, 8'sd8, 8'sd85, -8'sd85});
    cmd_backlog.push_back('{8'sd99, -8'sd99, -8'sd128, 8'sd127});
    cmd_backlog.push_back('{8'h55, 8'hAA, 8'h0F, 8'hF0});
    cmd_backlog.push_back('{8'hAA, 8'h55, 8'hF0, 8'h0F});
    drain_all();

    for (int set = 0; set < 6; set++) begin
      case (set)
        0: mask = 4'b0000;
        1: mask = 4'b1111;
        2: mask = 4'b0101;
        3: mask = 4'b1010;
        4: mask = 4'($urandom_range(0, 15));
        default: mask = 4'b0000;
      endcase
      for (int m = 0; m < NUM_MOTORS; m++) write_invert(CFG_INDEX_W'(m), mask[m]);
      // writes past the last register must leave the invert bits alone
      write_invert(CFG_INDEX_W'($urandom_range(NUM_MOTORS, 15)), 1'($urandom_range(0, 1)));

      count = 0;
      while (count < ITEMS_PER_SET) begin
        mode = $urandom_range(0, 4);
        run_len = $urandom_range(1, 16);
        if (mode == 4) begin
          // steady command so the average settles on it
          held = make_cmds($urandom_range(0, 3));
          repeat (run_len) cmd_backlog.push_back(held);
        end else begin
          repeat (run_len) cmd_backlog.push_back(make_cmds(mode));
        end
        count += run_len;
      end
      drain_all();
    end

    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
